// ===== rtl/afr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// Types, codes and defaults shared by the fragment reassembler modules.
// ----------------------------------------------------------------------------
package afr_pkg;

   localparam int CHANNEL_COUNT_DEF = 2;
   localparam int FOLLOW_HDR_DEF    = 1;

   localparam int LenW = 16;
   localparam int SduW = 24;
   localparam logic [SduW-1:0] LEN_MAX = '1;

   typedef enum logic [1:0] {
      PKT_SINGLE   = 2'd0,
      PKT_START    = 2'd1,
      PKT_CONTINUE = 2'd2,
      PKT_END      = 2'd3
   } ptype_type;

   typedef enum logic [2:0] {
      ACT_SINGLE    = 3'd0,
      ACT_START     = 3'd1,
      ACT_APPEND    = 3'd2,
      ACT_COMPLETE  = 3'd3,
      ACT_MALFORMED = 3'd4,
      ACT_DROPPED   = 3'd5,
      ACT_CLEARED   = 3'd6
   } action_type;

   typedef struct packed {
      logic            mode;
      logic            channel;
      ptype_type       ptype;
      logic [3:0]      label;
      logic            is_response;
      logic [7:0]      fragment_total;
      logic [LenW-1:0] pdu_length;
   } req_item_type;

   typedef struct packed {
      action_type      action;
      logic            channel;
      logic [SduW-1:0] sdu_length;
      logic [3:0]      label;
   } rsp_item_type;

   typedef struct packed {
      logic            active;
      logic [3:0]      label;
      logic            response;
      logic [7:0]      expected;
      logic [7:0]      received;
      logic [LenW-1:0] first_size;
      logic [SduW-1:0] assembled;
   } chan_state_type;

   // Handshake between the pipeline stages
   typedef struct packed {
      logic fire;      // input register hands its word to the result register
      logic out_free;  // result register can take a word this cycle
   } pipe_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/afr_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afr_in_stage
// Input register: holds one accepted header word until the engine takes it.
// ----------------------------------------------------------------------------
module afr_in_stage import afr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_item_type  req_item,
   input  pipe_ctrl_type ctrl_in,
   output logic          item_valid,
   output req_item_type  item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign req_ready = !valid_ff || ctrl_in.out_free;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (ctrl_in.fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ===== rtl/afr_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afr_engine
// Per-channel partial message state and the decision for one header word.
// ----------------------------------------------------------------------------
module afr_engine import afr_pkg::*; #(
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF,
   parameter int FOLLOW_HEADER_BYTES = FOLLOW_HDR_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  pipe_ctrl_type ctrl_in,
   input  req_item_type  item,
   output rsp_item_type  result
);

   localparam int ChanIdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam logic [LenW-1:0] FollowHdr = LenW'(FOLLOW_HEADER_BYTES);

   chan_state_type chan_ff [CHANNEL_COUNT];
   chan_state_type chan_in [CHANNEL_COUNT];
   chan_state_type sel;

   logic [ChanIdxW-1:0] chan_idx;
   logic                in_range;
   logic                match, type_ok, rcv_lt, rcv_eq, len_le, len_ne;
   logic [8:0]          rcv_next;
   logic [LenW-1:0]     follow_len;
   logic [SduW:0]       sum_raw;
   logic [SduW-1:0]     sum_sat;
   logic                do_clear, do_start, do_append;

   assign chan_idx = ChanIdxW'(item.channel);
   assign in_range = ({3'b000, item.channel} < 4'(CHANNEL_COUNT));

   always_comb begin
      sel = '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (chan_idx == ChanIdxW'(c)) begin
            sel = chan_ff[c];
         end
      end
   end

   // Compare received + 1 with expected, so that an expected count of zero never fits
   assign rcv_next   = {1'b0, sel.received} + 9'd1;
   assign rcv_lt     = rcv_next < {1'b0, sel.expected};
   assign rcv_eq     = rcv_next == {1'b0, sel.expected};
   assign match      = sel.active && (sel.label == item.label);
   assign type_ok    = sel.response == item.is_response;
   assign len_le     = item.pdu_length <= sel.first_size;
   assign len_ne     = item.pdu_length != sel.first_size;
   assign follow_len = (item.pdu_length > FollowHdr) ? (item.pdu_length - FollowHdr) : '0;
   assign sum_raw    = {1'b0, sel.assembled} + (SduW + 1)'(follow_len);
   assign sum_sat    = sum_raw[SduW] ? LEN_MAX : sum_raw[SduW-1:0];

   always_comb begin
      result            = '0;
      result.action     = ACT_DROPPED;
      result.channel    = item.channel;
      do_clear          = 1'b0;
      do_start          = 1'b0;
      do_append         = 1'b0;
      if (item.mode) begin
         result.action  = ACT_CLEARED;
         result.channel = 1'b0;
      end else if (in_range) begin
         unique case (item.ptype)
            PKT_SINGLE: begin
               result.action     = ACT_SINGLE;
               result.sdu_length = SduW'(item.pdu_length);
               result.label      = item.label;
               do_clear          = 1'b1;
            end
            PKT_START: begin
               result.action = ACT_START;
               do_start      = 1'b1;
            end
            PKT_CONTINUE: begin
               if (match && rcv_lt && type_ok && len_le) begin
                  result.action = ACT_APPEND;
                  do_append     = 1'b1;
               end else if (match && (!rcv_lt || len_ne || !type_ok)) begin
                  result.action = ACT_MALFORMED;
                  do_clear      = 1'b1;
               end
            end
            PKT_END: begin
               if (match && rcv_eq && type_ok && len_le) begin
                  result.action     = ACT_COMPLETE;
                  result.sdu_length = sum_sat;
                  result.label      = sel.label;
                  do_clear          = 1'b1;
               end else if (match && (!len_le || !type_ok)) begin
                  result.action = ACT_MALFORMED;
                  do_clear      = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         chan_in[c] = chan_ff[c];
         if (ctrl_in.fire) begin
            if (item.mode) begin
               chan_in[c] = '0;
            end else if (in_range && (chan_idx == ChanIdxW'(c))) begin
               if (do_clear) begin
                  chan_in[c] = '0;
               end else if (do_start) begin
                  chan_in[c].active     = 1'b1;
                  chan_in[c].label      = item.label;
                  chan_in[c].response   = item.is_response;
                  chan_in[c].expected   = item.fragment_total;
                  chan_in[c].received   = 8'd1;
                  chan_in[c].first_size = item.pdu_length;
                  chan_in[c].assembled  = (item.pdu_length != '0) ?
                                          SduW'(item.pdu_length - LenW'(1)) : '0;
               end else if (do_append) begin
                  chan_in[c].received  = rcv_next[7:0];
                  chan_in[c].assembled = sum_sat;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (reset) begin
            chan_ff[c] <= '0;
         end else begin
            chan_ff[c] <= chan_in[c];
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/afr_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afr_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module afr_out_stage import afr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  rsp_item_type  result,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item,
   output pipe_ctrl_type ctrl_out
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign ctrl_out.out_free = !valid_ff || rsp_ready;
   assign ctrl_out.fire     = item_valid && ctrl_out.out_free;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (ctrl_out.fire) begin
         valid_in = 1'b1;
         item_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
`default_nettype wire

// ===== rtl/avctp_fragment_reassembler.sv =====
`default_nettype none
// An accepted req word reaches rsp through the input register and then the result register.
// One word per cycle unless rsp stalls; per-channel state is read, decided and written per word.
// Back pressure on rsp stalls the input register; req_tready stays high while it is empty.
// Reset: synchronous, active high; clears every channel's partial message and empties both
// registers. The block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// avctp_fragment_reassembler
// Per-channel reassembly checker for fragmented transport packet headers.
// ----------------------------------------------------------------------------
module avctp_fragment_reassembler import afr_pkg::*; #(
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF,
   parameter int FOLLOW_HEADER_BYTES = FOLLOW_HDR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Header words in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // channel, label[3:0], is_response,
                                    // fragment_total[7:0], pdu_length[15:0], zero pad
   input  logic [2:0]  req_tuser,   // mode, packet_type[1:0]
   // Result words out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_channel, sdu_length[23:0], out_label[3:0], zero pad
   output logic [2:0]  rsp_tuser    // action[2:0]
);

   req_item_type  req_item, item;
   rsp_item_type  result, rsp_item;
   pipe_ctrl_type ctrl;
   logic          item_valid;

   // Unpack the header word
   always_comb begin
      req_item                = '0;
      req_item.mode           = req_tuser[0];
      req_item.ptype          = ptype_type'(req_tuser[2:1]);
      req_item.channel        = req_tdata[0];
      req_item.label          = req_tdata[4:1];
      req_item.is_response    = req_tdata[5];
      req_item.fragment_total = req_tdata[13:6];
      req_item.pdu_length     = req_tdata[29:14];
   end

   // Hold the accepted word until the result register frees up
   afr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .ctrl_in    (ctrl),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decide and advance the channel state on each fire
   afr_engine #(
      .CHANNEL_COUNT       (CHANNEL_COUNT),
      .FOLLOW_HEADER_BYTES (FOLLOW_HEADER_BYTES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (ctrl),
      .item    (item),
      .result  (result)
   );

   // Register the result and drive the rsp channel
   afr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item),
      .ctrl_out   (ctrl)
   );

   // Pack the result word; pad bits stay zero
   assign rsp_tdata = {3'b000, rsp_item.label, rsp_item.sdu_length, rsp_item.channel};
   assign rsp_tuser = rsp_item.action;

endmodule
`default_nettype wire

// ===== rtl/afr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afr_checker
// Port-level assertions for the fragment reassembler, bound to the top level.
// ----------------------------------------------------------------------------
module afr_checker import afr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("afr: stalled result word changed");

   // Length and label are only reported for delivered messages
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ACT_SINGLE) && (rsp_tuser != ACT_COMPLETE)
      |-> rsp_tdata[28:1] == '0)
      else $error("afr: length or label on a non-delivery result");

   // A clear event reports channel zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ACT_CLEARED) |-> !rsp_tdata[0])
      else $error("afr: cleared result with non-zero channel");

   // No result word straight after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("afr: result word valid after reset");

   // A word accepted while rsp_tvalid is low, with rsp_tready once it is in the input register, reaches the output
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid ##1 rsp_tready |=> rsp_tvalid)
      else $error("afr: accepted word did not reach the output");

endmodule

bind avctp_fragment_reassembler afr_checker u_afr_checker (.*);
`default_nettype wire
